// ===== src/dze_pkg.sv =====
// Shared types and constants for the depth delta encoder.
// No dependencies; imported by every module of the block.
package dze_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_BYTES   = 4;
  localparam int BIDX_W      = $clog2(MAX_BYTES);

  localparam logic [15:0] SMALL_LIMIT = 16'd6;
  localparam logic [15:0] MID_LIMIT   = 16'd63;
  localparam logic [3:0]  NIB_BIAS    = 4'd6;
  localparam logic [7:0]  ZERO_PAIR   = 8'h66;
  localparam logic [3:0]  ZC_LAST     = 4'd14;
  localparam logic [7:0]  ZC_FULL     = 8'hEF;
  localparam logic [3:0]  ZC_PREFIX   = 4'hE;
  localparam logic [7:0]  ESC_BYTE    = 8'hFF;
  localparam logic [7:0]  ESC_NIB     = 8'h0F;
  localparam logic [7:0]  MID_BIAS    = 8'd192;
  localparam logic [7:0]  CLOSE_NIB   = 8'h0D;

  // All bytes caused by one input sample.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [BIDX_W-1:0]         last_idx;
    logic                      frame_end;
  } bundle_t;

endpackage

// ===== src/dze_front.sv =====
// Front end: classifies each sample, keeps the coder state and builds a
// bundle of up to four output bytes. Depends on dze_pkg.
module dze_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [15:0]      sample,
  input  logic             frame_first,
  input  logic             frame_last,
  output dze_pkg::bundle_t bundle,
  output logic             has_bytes
);
  import dze_pkg::*;

  logic [15:0] previous_sample;
  logic        nibble_pending, nibble_pending_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [3:0]  zero_pair_count, zero_pair_count_next;

  logic [15:0] diff, mag;
  logic        is_small, mid;
  logic [3:0]  nib;
  logic [7:0]  pair_byte, esc_byte;
  logic [MAX_BYTES-1:0][7:0] bytes;
  logic [BIDX_W:0] n;

  assign diff  = previous_sample - sample;
  assign mag   = diff[15] ? (~diff + 16'd1) : diff;  // 0x8000 stays large
  assign is_small = (mag <= SMALL_LIMIT);
  assign mid   = (mag <= MID_LIMIT);
  assign nib   = diff[3:0] + NIB_BIAS;
  assign pair_byte = held_byte + {4'b0, nib};
  assign esc_byte  = nibble_pending ? (held_byte + ESC_NIB) : ESC_BYTE;

  always_comb begin
    nibble_pending_next  = nibble_pending;
    held_byte_next       = held_byte;
    zero_pair_count_next = zero_pair_count;
    bytes = '0;
    n     = '0;
    if (frame_first) begin
      nibble_pending_next  = 1'b0;
      held_byte_next       = '0;
      zero_pair_count_next = '0;
      bytes[0] = sample[7:0];
      bytes[1] = sample[15:8];
      n = 3'd2;
    end else if (is_small) begin
      if (!nibble_pending) begin
        held_byte_next      = {nib, 4'b0};
        nibble_pending_next = 1'b1;
      end else begin
        held_byte_next      = pair_byte;
        nibble_pending_next = 1'b0;
        if (pair_byte == ZERO_PAIR) begin
          if (zero_pair_count == ZC_LAST) begin
            bytes[n[BIDX_W-1:0]] = ZC_FULL;
            n = n + 1'b1;
            zero_pair_count_next = '0;
          end else begin
            zero_pair_count_next = zero_pair_count + 4'd1;
          end
        end else begin
          if (zero_pair_count != '0) begin
            bytes[n[BIDX_W-1:0]] = {ZC_PREFIX, zero_pair_count};
            n = n + 1'b1;
            zero_pair_count_next = '0;
          end
          bytes[n[BIDX_W-1:0]] = pair_byte;
          n = n + 1'b1;
        end
      end
    end else begin
      if (zero_pair_count != '0) begin
        bytes[n[BIDX_W-1:0]] = {ZC_PREFIX, zero_pair_count};
        n = n + 1'b1;
        zero_pair_count_next = '0;
      end
      held_byte_next      = esc_byte;
      nibble_pending_next = 1'b0;
      bytes[n[BIDX_W-1:0]] = esc_byte;
      n = n + 1'b1;
      if (mid) begin
        bytes[n[BIDX_W-1:0]] = diff[7:0] + MID_BIAS;
        n = n + 1'b1;
      end else begin
        bytes[n[BIDX_W-1:0]] = sample[15:8];
        n = n + 1'b1;
        bytes[n[BIDX_W-1:0]] = sample[7:0];
        n = n + 1'b1;
      end
    end
    // end of frame: close a held nibble, then drain the zero pairs
    if (frame_last) begin
      if (nibble_pending_next) begin
        bytes[n[BIDX_W-1:0]] = held_byte_next + CLOSE_NIB;
        n = n + 1'b1;
        nibble_pending_next = 1'b0;
      end
      if (zero_pair_count_next != '0) begin
        bytes[n[BIDX_W-1:0]] = {ZC_PREFIX, zero_pair_count_next};
        n = n + 1'b1;
        zero_pair_count_next = '0;
      end
    end
  end

  assign has_bytes        = (n != '0);
  assign bundle.bytes     = bytes;
  assign bundle.last_idx  = n[BIDX_W-1:0] - 1'b1;
  assign bundle.frame_end = frame_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      nibble_pending  <= 1'b0;
      held_byte       <= '0;
      zero_pair_count <= '0;
    end else if (accept) begin
      previous_sample <= sample;
      nibble_pending  <= nibble_pending_next;
      held_byte       <= held_byte_next;
      zero_pair_count <= zero_pair_count_next;
    end
  end

endmodule

// ===== src/dze_queue.sv =====
// Short bundle queue between the front end and the byte serializer.
// Depends on dze_pkg.
module dze_queue #(
  parameter int DEPTH = dze_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             enq,
  input  dze_pkg::bundle_t enq_data,
  input  logic             deq,
  output dze_pkg::bundle_t head,
  output logic             full,
  output logic             empty
);
  import dze_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_CNT = (AW + 1)'(DEPTH);

  bundle_t       mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full  = (count == DEPTH_CNT);
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) mem[wr_ptr] <= enq_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (deq) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      case ({enq, deq})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/dze_back.sv =====
// Back end: walks the bytes of the head bundle, one word per pop.
// Depends on dze_pkg.
module dze_back (
  input  logic             clk,
  input  logic             rst,
  input  dze_pkg::bundle_t head,
  input  logic             head_empty,
  input  logic             pop,
  output logic             deq,
  output logic             empty,
  output logic [7:0]       code_byte,
  output logic             run_last,
  output logic             frame_end
);
  import dze_pkg::*;

  logic [BIDX_W-1:0] idx;
  logic              fire, at_last;

  assign empty     = head_empty;
  assign fire      = pop && !head_empty;
  assign at_last   = (idx == head.last_idx);
  assign deq       = fire && at_last;
  assign code_byte = head.bytes[idx];
  assign run_last  = at_last;
  assign frame_end = at_last && head.frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire) begin
      idx <= at_last ? '0 : idx + 1'b1;
    end
  end

endmodule

// ===== src/depth16z_delta_encoder.sv =====
// Depth delta encoder top level: front end, bundle queue, byte serializer.
// Depends on dze_pkg, dze_front, dze_queue, dze_back.
//
// Usage:
//   Input side is a queue write port: an item (sample, frame_first,
//   frame_last) is taken on a clock edge with push high and full low.
//   Output side is a queue read port: while empty is low the oldest
//   word (code_byte, run_last, frame_end) is on the ports and leaves on
//   an edge with pop high. Each sample yields zero to four words; a
//   sample that yields none leaves nothing on the output.
//   A sample's words are written into the queue on the edge that takes
//   it and reach the ports once the words ahead of them have left.
//   Throughput: one sample per cycle in while full is low; one word
//   per cycle out while pop is high. The front end codes a sample
//   combinationally; the output drains one word a cycle, so bursts of up
//   to four words per sample are held in a queue of QUEUE_DEPTH bundles.
//   When the receiver stalls the queue fills and full rises for a sample
//   that needs a slot; a sample that yields no words is still taken.
//   Reset (rst, synchronous) clears the coder state to zero and empties
//   the queue.
module depth16z_delta_encoder #(
  parameter int QUEUE_DEPTH = dze_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] sample,
  input  logic        frame_first,
  input  logic        frame_last,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  code_byte,
  output logic        run_last,
  output logic        frame_end
);
  import dze_pkg::*;

  bundle_t bundle, head;
  logic    has_bytes, accept, enq, deq, q_full, q_empty;

  // a sample with no words never needs a queue slot
  assign full   = q_full && has_bytes;
  assign accept = push && !full;
  assign enq    = accept && has_bytes;

  dze_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .sample      (sample),
    .frame_first (frame_first),
    .frame_last  (frame_last),
    .bundle      (bundle),
    .has_bytes   (has_bytes)
  );

  dze_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .enq      (enq),
    .enq_data (bundle),
    .deq      (deq),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  dze_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (q_empty),
    .pop        (pop),
    .deq        (deq),
    .empty      (empty),
    .code_byte  (code_byte),
    .run_last   (run_last),
    .frame_end  (frame_end)
  );

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) ($past(rst) && !rst) |-> empty)
    else $error("output not empty after reset");

  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_end) |-> run_last)
    else $error("frame_end word is not the last word of its sample");

  a_first_emits: assert property (@(posedge clk)
    (!rst && push && !full && frame_first) |=> !empty)
    else $error("frame start produced no output word");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for depth16z_delta_encoder: directed and random depth frames.
// It predicts each code word from its own model of the 16z delta coder.
// Depends on dze_pkg for the code byte constants.
module tb;
  import dze_pkg::*;

  localparam int TOTAL_ITEMS    = 310;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [7:0] code;
    logic       run_last;
    logic       frame_end;
  } code_word_t;

  typedef enum int {FLAT, SMOOTH, MIXED, MIDRANGE, WIDE} frame_flavor_t;

  // Model of the coder state plus the words still owed by the block.
  class delta_code_board;
    code_word_t  pending_words[$];
    logic [7:0]  burst[$];
    int          errors;
    logic [15:0] last_sample;
    logic        half_pending;
    logic [7:0]  byte_acc;
    logic [3:0]  pair_count;

    function new();
      errors       = 0;
      last_sample  = '0;
      half_pending = 1'b0;
      byte_acc     = '0;
      pair_count   = '0;
    endfunction

    function void emit_pairs();
      if (pair_count != 0) begin
        burst.push_back({ZC_PREFIX, pair_count});
        pair_count = '0;
      end
    endfunction

    function void note_sample(logic [15:0] cur, logic is_first, logic is_last);
      logic [15:0] diff;
      logic [3:0]  nib;
      int          sdiff;
      int          mag;
      code_word_t  w;
      burst.delete();
      if (is_first) begin
        // a new frame drops whatever the old one still held
        half_pending = 1'b0;
        byte_acc     = '0;
        pair_count   = '0;
        burst.push_back(cur[7:0]);
        burst.push_back(cur[15:8]);
      end else begin
        diff  = last_sample - cur;
        sdiff = diff[15] ? int'(diff) - 65536 : int'(diff);
        mag   = (sdiff < 0) ? -sdiff : sdiff;
        if (mag <= int'(SMALL_LIMIT)) begin
          nib = 4'(sdiff + int'(NIB_BIAS));
          if (!half_pending) begin
            byte_acc     = {nib, 4'h0};
            half_pending = 1'b1;
          end else begin
            byte_acc     = byte_acc + {4'h0, nib};
            half_pending = 1'b0;
            if (byte_acc == ZERO_PAIR) begin
              pair_count = pair_count + 4'd1;
              if (pair_count == 4'hF) begin
                burst.push_back(ZC_FULL);
                pair_count = '0;
              end
            end else begin
              emit_pairs();
              burst.push_back(byte_acc);
            end
          end
        end else begin
          emit_pairs();
          if (!half_pending) begin
            byte_acc = ESC_BYTE;
          end else begin
            byte_acc     = byte_acc + ESC_NIB;
            half_pending = 1'b0;
          end
          burst.push_back(byte_acc);
          if (mag <= int'(MID_LIMIT)) begin
            burst.push_back(8'(sdiff + int'(MID_BIAS)));
          end else begin
            burst.push_back(cur[15:8]);
            burst.push_back(cur[7:0]);
          end
        end
      end
      last_sample = cur;
      if (is_last) begin
        if (half_pending) begin
          burst.push_back(byte_acc + CLOSE_NIB);
          half_pending = 1'b0;
        end
        emit_pairs();
      end
      foreach (burst[i]) begin
        w.code      = burst[i];
        w.run_last  = (i == burst.size() - 1);
        w.frame_end = w.run_last && is_last;
        pending_words.push_back(w);
      end
    endfunction

    function void check_word(logic [7:0] code, logic rl, logic fe);
      code_word_t want;
      if (pending_words.size() == 0) begin
        $error("code_byte 0x%02h arrived with no word expected", code);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (code !== want.code) begin
        $error("code_byte: expected 0x%02h, actual 0x%02h", want.code, code);
        errors++;
      end
      if (rl !== want.run_last) begin
        $error("run_last: expected %0b, actual %0b", want.run_last, rl);
        errors++;
      end
      if (fe !== want.frame_end) begin
        $error("frame_end: expected %0b, actual %0b", want.frame_end, fe);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] sample = '0;
  logic        frame_first = 1'b0;
  logic        frame_last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  code_byte;
  logic        run_last;
  logic        frame_end;

  delta_code_board board;
  int sent;
  int idle_cycles;

  depth16z_delta_encoder uut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .sample      (sample),
    .frame_first (frame_first),
    .frame_last  (frame_last),
    .empty       (empty),
    .pop         (pop),
    .code_byte   (code_byte),
    .run_last    (run_last),
    .frame_end   (frame_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Scoreboard hooks and the stall watchdog, all on the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (push && !full) board.note_sample(sample, frame_first, frame_last);
      if (pop && !empty) board.check_word(code_byte, run_last, frame_end);
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Called right after a rising edge; returns at the edge that takes the sample.
  task automatic send(logic [15:0] s, logic f, logic l, int gap_max);
    int gap;
    gap = $urandom_range(0, gap_max);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample      <= s;
    frame_first <= f;
    frame_last  <= l;
    push        <= 1'b1;
    @(posedge clk);
    while (!(push && !full)) begin
      @(negedge clk);
      push <= 1'b1;
      @(posedge clk);
    end
    sent++;
  endtask

  // Difference previous - current for the next sample of a frame.
  function automatic int pick_delta(frame_flavor_t flavor);
    int mag;
    case (flavor)
      FLAT:     return ($urandom_range(0, 15) == 0) ? int'($urandom_range(0, 12)) - 6 : 0;
      SMOOTH:   return int'($urandom_range(0, 12)) - 6;
      MIDRANGE: begin
        mag = int'($urandom_range(7, 70));
        return $urandom_range(0, 1) ? mag : -mag;
      end
      WIDE:     return int'($urandom_range(0, 65535));
      default:  return pick_delta(frame_flavor_t'($urandom_range(0, 3)));
    endcase
  endfunction

  initial begin : drain_words
    int gap;
    int gap_max;
    int taken;
    taken   = 0;
    gap_max = 17;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (taken % 20 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
      // two long hold-offs let the block fill up and raise full
      gap = (taken == 50 || taken == 250) ? LONG_HOLD : $urandom_range(0, gap_max);
      @(negedge clk);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      taken++;
    end
  end

  initial begin : feed_samples
    frame_flavor_t flavor;
    logic [15:0]   cur;
    int            len;
    int            gap_max;
    logic          open_start;
    logic          open_end;
    board = new();
    sent  = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no frame start right after reset, then a restart over a held nibble
    send(16'h0003, 1'b0, 1'b0, 3);
    send(16'h0000, 1'b0, 1'b0, 3);
    send(16'h0000, 1'b0, 1'b0, 3);
    send(16'h0000, 1'b0, 1'b0, 3);
    send(16'h0005, 1'b0, 1'b0, 3);
    send(16'h1234, 1'b1, 1'b0, 3);
    // zero pair, nibble extremes, escape boundaries
    send(16'h1234, 1'b0, 1'b0, 3);
    send(16'h1234, 1'b0, 1'b0, 3);
    send(16'h122E, 1'b0, 1'b0, 3);
    send(16'h1234, 1'b0, 1'b0, 3);
    send(16'h11F5, 1'b0, 1'b0, 3);
    send(16'h1234, 1'b0, 1'b0, 3);
    send(16'h122D, 1'b0, 1'b0, 3);
    send(16'h11ED, 1'b0, 1'b0, 3);
    send(16'h11ED, 1'b0, 1'b0, 3);
    send(16'h1201, 1'b0, 1'b0, 3);
    send(16'h9201, 1'b0, 1'b0, 3);
    // difference of exactly -32768, then the 16-bit wrap
    send(16'h1201, 1'b0, 1'b0, 3);
    send(16'hFFFF, 1'b0, 1'b0, 3);
    send(16'h0000, 1'b0, 1'b0, 3);
    send(16'h0000, 1'b0, 1'b0, 3);
    send(16'h0000, 1'b0, 1'b0, 3);
    // frame end with a held nibble and a pending zero pair
    send(16'h0000, 1'b0, 1'b1, 3);
    send(16'h8001, 1'b1, 1'b1, 3);
    send(16'h8000, 1'b0, 1'b1, 3);

    @(negedge clk);
    push <= 1'b0;
    while (board.pending_words.size() != 0) @(posedge clk);

    while (sent < TOTAL_ITEMS) begin
      flavor = frame_flavor_t'($urandom_range(0, 4));
      if (flavor == FLAT) len = $urandom_range(20, 48);
      else len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
      open_start = ($urandom_range(0, 11) == 0);
      open_end   = ($urandom_range(0, 9) == 0);
      gap_max    = ($urandom_range(0, 2) == 0) ? 0 : 17;
      cur        = 16'($urandom);
      for (int i = 0; i < len; i++) begin
        if (i != 0) cur = cur - 16'(pick_delta(flavor));
        send(cur, (i == 0) && !open_start, (i == len - 1) && !open_end, gap_max);
      end
    end

    @(negedge clk);
    push <= 1'b0;
    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
